### sv/odo_pkg.sv
// Shared types and constants for the path-length odometer.
// No dependencies; compiled first.
`default_nettype none

package odo_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REST,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_ROOT,
        ST_ACC
    } t_odo_state;

    // Input beat selector codes
    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_RESTORE = 1'b1;

    // Fixed payload widths
    localparam int unsigned MILE_IO_W = 48;
    localparam int unsigned STEP_W    = 25;
    localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

    // Register port
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned SI_W   = 16;
    localparam logic [0:0] REG_SAVE_PERIOD = 1'b0;
    localparam logic [SI_W-1:0] SAVE_PERIOD_RST = 16'd500;

endpackage

`default_nettype wire

### sv/odo_in_if.sv
// Input channel: position sample or mileage restore beat.
// Depends on odo_pkg for the restore field width.
`default_nettype none

interface odo_in_if #(
    parameter int POS_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic signed [POS_WIDTH-1:0]    pos_x;
    logic signed [POS_WIDTH-1:0]    pos_y;
    logic [odo_pkg::MILE_IO_W-1:0]  restored_mileage;

    modport source (output valid, func, pos_x, pos_y, restored_mileage, input ready);
    modport sink   (input valid, func, pos_x, pos_y, restored_mileage, output ready);
endinterface

`default_nettype wire

### sv/odo_out_if.sv
// Result channel: running total, step distance, save request.
// Depends on odo_pkg for field widths.
`default_nettype none

interface odo_out_if;
    logic                           valid;
    logic                           ready;
    logic [odo_pkg::MILE_IO_W-1:0]  total_mileage;
    logic [odo_pkg::STEP_W-1:0]     step_distance;
    logic                           save_request;

    modport source (output valid, total_mileage, step_distance, save_request, input ready);
    modport sink   (input valid, total_mileage, step_distance, save_request, output ready);
endinterface

`default_nettype wire

### sv/odometry_distance_accumulator_core.sv
// Path-length odometer top level: sequencer, shared squarer, bit-serial root.
// Depends on odo_pkg, odo_in_if and odo_out_if.
`default_nettype none

// Accumulates the floor Euclidean distance between consecutive position
// samples into a saturating mileage total. The first sample after reset is
// only latched. Every later sample is accepted in IDLE, then passes DIFF, two
// squarings on the single shared multiplier, a sum step, the restoring square
// root (one root bit per cycle) and an accumulate step; no new beat is taken
// until the sequencer is back in IDLE. A restore beat passes through REST;
// a first sample stays in IDLE. The result sits in an output register, so a
// new beat is taken while an earlier result still waits; the accumulate
// state holds only if a second result would overwrite an untaken one.
// The save period (steps between save requests) is the only register, at
// byte address 0 (reset 500, zero acts as one).
module odometry_distance_accumulator_core #(
    parameter int POS_WIDTH     = 24,
    parameter int MILEAGE_WIDTH = 48
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    odo_in_if.sink                          i_in,
    odo_out_if.source                       o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [odo_pkg::ADDR_W-1:0] paddr,
    input  wire logic [odo_pkg::DATA_W-1:0] pwdata,
    output logic      [odo_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int PW1 = POS_WIDTH + 1;           // |dx| width
    localparam int RB  = POS_WIDTH + 2;           // root bits
    localparam int RW  = 2 * RB;                  // radicand width
    localparam int CW  = $clog2(RB);
    localparam int MW  = MILEAGE_WIDTH;
    localparam int AW  = ((MW > RB) ? MW : RB) + 1;
    localparam int DW  = (RB > odo_pkg::STEP_W) ? RB : odo_pkg::STEP_W;
    localparam logic [MW-1:0] MILE_MAX = {MW{1'b1}};

    // ---------------- register port ----------------
    logic [odo_pkg::SI_W-1:0] r_save_period;
    logic                     s_reg_hit;

    assign pready    = 1'b1;
    assign s_reg_hit = (paddr[odo_pkg::ADDR_W-1:2] == odo_pkg::REG_SAVE_PERIOD);
    assign prdata    = s_reg_hit ? odo_pkg::DATA_W'(r_save_period) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_save_period <= odo_pkg::SAVE_PERIOD_RST;
        end else if (psel && penable && pwrite && pready && s_reg_hit) begin
            r_save_period <= pwdata[odo_pkg::SI_W-1:0];
        end
    end

    // ---------------- state ----------------
    odo_pkg::t_odo_state r_state, n_state;

    logic                           r_have_prev;
    logic [odo_pkg::SI_W-1:0]       r_save_cnt;
    logic [MW-1:0]                  r_total;
    logic                           r_out_valid;

    // beat latches and working registers (payload, no reset)
    logic [POS_WIDTH-1:0]           r_x, r_y, r_prev_x, r_prev_y;
    logic [odo_pkg::MILE_IO_W-1:0]  r_restore;
    logic [PW1-1:0]                 r_ax, r_ay;
    logic [2*PW1-1:0]               r_prod;
    logic [RW-1:0]                  r_rad;
    logic [RB:0]                    r_rem;
    logic [RB-1:0]                  r_root;
    logic [CW-1:0]                  r_cnt;
    logic [odo_pkg::MILE_IO_W-1:0]  r_out_total;
    logic [odo_pkg::STEP_W-1:0]     r_out_step;
    logic                           r_out_req;

    // sequencer outputs
    logic s_in_ready;
    logic s_in_acc;
    logic s_emit;
    logic s_mul_y;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            odo_pkg::ST_IDLE: begin
                if (s_in_acc) begin
                    if (i_in.func == odo_pkg::FUNC_RESTORE) begin
                        n_state = odo_pkg::ST_REST;
                    end else if (r_have_prev) begin
                        n_state = odo_pkg::ST_DIFF;
                    end
                end
            end
            odo_pkg::ST_REST: n_state = odo_pkg::ST_IDLE;
            odo_pkg::ST_DIFF: n_state = odo_pkg::ST_SQX;
            odo_pkg::ST_SQX:  n_state = odo_pkg::ST_SQY;
            odo_pkg::ST_SQY:  n_state = odo_pkg::ST_SUM;
            odo_pkg::ST_SUM:  n_state = odo_pkg::ST_ROOT;
            odo_pkg::ST_ROOT: begin
                if (r_cnt == '0) begin
                    n_state = odo_pkg::ST_ACC;
                end
            end
            odo_pkg::ST_ACC: begin
                if (s_emit) begin
                    n_state = odo_pkg::ST_IDLE;
                end
            end
            default: n_state = odo_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        s_in_ready = 1'b0;
        s_emit     = 1'b0;
        s_mul_y    = 1'b0;
        unique case (r_state)
            odo_pkg::ST_IDLE: s_in_ready = 1'b1;
            odo_pkg::ST_SQY:  s_mul_y    = 1'b1;
            odo_pkg::ST_ACC:  s_emit     = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    assign i_in.ready = s_in_ready;
    assign s_in_acc   = i_in.valid && s_in_ready;

    // ---------------- datapath ----------------
    // difference and magnitude
    logic signed [PW1-1:0] s_dx, s_dy;
    assign s_dx = $signed({r_x[POS_WIDTH-1], r_x}) - $signed({r_prev_x[POS_WIDTH-1], r_prev_x});
    assign s_dy = $signed({r_y[POS_WIDTH-1], r_y}) - $signed({r_prev_y[POS_WIDTH-1], r_prev_y});

    // shared squarer
    logic [PW1-1:0]   s_mop;
    logic [2*PW1-1:0] s_prod;
    assign s_mop  = s_mul_y ? r_ay : r_ax;
    assign s_prod = s_mop * s_mop;

    // one restoring square-root step
    logic [RB+2:0] s_rem_sh, s_trial, s_rem_nx;
    logic          s_ge;
    assign s_rem_sh = {r_rem, r_rad[RW-1 -: 2]};
    assign s_trial  = (RB+3)'({r_root, 2'b01});
    assign s_ge     = (s_rem_sh >= s_trial);
    assign s_rem_nx = s_ge ? (s_rem_sh - s_trial) : s_rem_sh;

    // saturating accumulate
    logic [AW-1:0] s_sum;
    logic [MW-1:0] s_total_nx;
    assign s_sum      = AW'(r_total) + AW'(r_root);
    assign s_total_nx = (s_sum[AW-1:MW] != '0) ? MILE_MAX : s_sum[MW-1:0];

    // step field clamps only for wide positions
    logic [DW-1:0]              s_dist_w;
    logic [odo_pkg::STEP_W-1:0] s_step;
    assign s_dist_w = DW'(r_root);
    assign s_step   = (s_dist_w > DW'(odo_pkg::STEP_MAX)) ? odo_pkg::STEP_MAX
                                                          : s_dist_w[odo_pkg::STEP_W-1:0];

    // save pacing; zero period acts as one
    logic [odo_pkg::SI_W-1:0] s_intv;
    logic                     s_req;
    assign s_intv = (r_save_period == '0) ? odo_pkg::SI_W'(1) : r_save_period;
    assign s_req  = (r_save_cnt >= s_intv);

    // restore value, low MILEAGE_WIDTH bits
    logic [MW-1:0] s_rest_v;
    assign s_rest_v = MW'(r_restore);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= odo_pkg::ST_IDLE;
            r_have_prev <= 1'b0;
            r_save_cnt  <= odo_pkg::SI_W'(1);
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_in_acc && i_in.func == odo_pkg::FUNC_SAMPLE) begin
                r_have_prev <= 1'b1;
            end
            if (r_state == odo_pkg::ST_REST && s_rest_v > r_total) begin
                r_total <= s_rest_v;
            end
            if (s_emit) begin
                r_total     <= s_total_nx;
                r_save_cnt  <= s_req ? odo_pkg::SI_W'(1) : r_save_cnt + 1'b1;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_x       <= i_in.pos_x;
            r_y       <= i_in.pos_y;
            r_restore <= i_in.restored_mileage;
            // first sample only seeds the previous position
            if (i_in.func == odo_pkg::FUNC_SAMPLE && !r_have_prev) begin
                r_prev_x <= i_in.pos_x;
                r_prev_y <= i_in.pos_y;
            end
        end
        unique case (r_state)
            odo_pkg::ST_DIFF: begin
                r_ax     <= s_dx[PW1-1] ? PW1'(-s_dx) : PW1'(s_dx);
                r_ay     <= s_dy[PW1-1] ? PW1'(-s_dy) : PW1'(s_dy);
                r_prev_x <= r_x;
                r_prev_y <= r_y;
            end
            odo_pkg::ST_SQX: r_prod <= s_prod;
            odo_pkg::ST_SQY: begin
                r_rad  <= RW'(r_prod);
                r_prod <= s_prod;
            end
            odo_pkg::ST_SUM: begin
                r_rad  <= r_rad + RW'(r_prod);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CW'(RB - 1);
            end
            odo_pkg::ST_ROOT: begin
                r_rem  <= s_rem_nx[RB:0];
                r_root <= {r_root[RB-2:0], s_ge};
                r_rad  <= r_rad << 2;
                r_cnt  <= r_cnt - 1'b1;
            end
            odo_pkg::ST_ACC: begin
                if (s_emit) begin
                    r_out_total <= odo_pkg::MILE_IO_W'(s_total_nx);
                    r_out_step  <= s_step;
                    r_out_req   <= s_req;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.total_mileage = r_out_total;
    assign o_out.step_distance = r_out_step;
    assign o_out.save_request  = r_out_req;

endmodule

`default_nettype wire
